@@ design/tgbu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tgbu_pkg;

  // Widths of the fixed fields.
  localparam int DATA_W    = 16;
  localparam int COUNT_W   = 11;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int COORD_W   = 7;
  localparam int STATUS_W  = 3;
  localparam int CELLS_W   = 2 * CFG_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0]   RESET_DIM = 6'd8;

  typedef logic signed [DATA_W-1:0] sample_t;

  // Item kinds.
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_COMMITTED = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_READ_OOR  = 3'd4
  } status_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 2'd0,
    CFG_GRID_HEIGHT = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

@@ design/tgbu_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tgbu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/tgbu_lerp.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Pipelined step between two Q8.8 values: a + floor(t * (b - a) / STEPS).
// The difference is split as d = q * STEPS + r with 0 <= r < STEPS, so the
// result is a + t * q + floor(t * r / STEPS). A new operation may enter every
// cycle.
module tgbu_lerp #(
  parameter int STEPS = 4,
  localparam int TW = (STEPS > 1) ? $clog2(STEPS) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire tgbu_pkg::sample_t a,
  input  wire tgbu_pkg::sample_t b,
  input  wire logic [TW-1:0]     t,
  output logic                   out_valid,
  output tgbu_pkg::sample_t      result
);

  import tgbu_pkg::*;

  localparam int DP_W   = 18;
  localparam int OFFS   = STEPS * ((65536 + STEPS - 1) / STEPS);
  localparam int QOFF   = OFFS / STEPS;
  localparam int QSH    = 22;
  localparam int RECIP  = ((2 ** QSH) + STEPS - 1) / STEPS;
  localparam int FSH    = 12;
  localparam int FRECIP = ((2 ** FSH) + STEPS - 1) / STEPS;
  localparam int Q_W    = DP_W + 1;
  localparam int TQ_W   = Q_W + TW + 1;
  localparam int TR_W   = 2 * TW;
  localparam int SUM_W  = TQ_W + 1;

  localparam logic [QSH:0] RECIP_C  = (QSH + 1)'(RECIP);
  localparam logic [FSH:0] FRECIP_C = (FSH + 1)'(FRECIP);

  logic [4:0] v;

  sample_t a1, a2, a3, a4, a5;
  logic [TW-1:0] t1, t2, t3;
  logic [DP_W-1:0] dp1, dp2, qp2;
  logic [TW-1:0] r3;
  logic signed [TQ_W-1:0] tq3, tq4, tq5;
  logic [TR_W-1:0] tr4;
  logic [TW-1:0] f5;

  logic signed [DATA_W:0] diff;
  logic [DP_W+QSH:0] qprod;
  logic [DP_W-1:0] rfull;
  logic signed [Q_W-1:0] q;
  logic [TR_W+FSH:0] fprod;
  logic signed [SUM_W-1:0] sum;

  // Stage one: biased difference, forced to zero when no step is taken.
  always_comb begin
    diff = (t == '0) ? '0 : ((DATA_W + 1)'(b) - (DATA_W + 1)'(a));
  end

  // Stage two: quotient of the biased difference by a reciprocal.
  always_comb begin
    qprod = (DP_W + QSH + 1)'(dp1) * (DP_W + QSH + 1)'(RECIP_C);
  end

  // Stage three: remainder and the whole-step part t * q.
  always_comb begin
    rfull = dp2 - DP_W'(32'(qp2) * STEPS);
    q     = $signed({1'b0, qp2}) - Q_W'(QOFF);
  end

  // Stage five: fractional part floor(t * r / STEPS).
  always_comb begin
    fprod = (TR_W + FSH + 1)'(tr4) * (TR_W + FSH + 1)'(FRECIP_C);
  end

  always_comb begin
    sum = SUM_W'(a5) + SUM_W'(tq5) + $signed(SUM_W'({1'b0, f5}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[3:0], in_valid};
    end
    a1  <= a;
    t1  <= t;
    dp1 <= DP_W'(diff) + DP_W'(OFFS);
    a2  <= a1;
    t2  <= t1;
    dp2 <= dp1;
    qp2 <= qprod[QSH +: DP_W];
    a3  <= a2;
    t3  <= t2;
    r3  <= TW'(rfull);
    tq3 <= TQ_W'(q) * TQ_W'($signed({1'b0, t2}));
    a4  <= a3;
    tq4 <= tq3;
    tr4 <= TR_W'(t3) * TR_W'(r3);
    a5  <= a4;
    tq5 <= tq4;
    f5  <= fprod[FSH +: TW];
  end

  assign out_valid = v[4];
  assign result    = sample_t'(sum[DATA_W-1:0]);

endmodule

`default_nettype wire

@@ design/thermal_grid_bilinear_upscale.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bilinear upscaler for a small thermal frame.
// Input channel (in_valid / in_ready): a beat either loads one Q8.8 sample of
// a frame in row-major order (kind 0, frame_end on the last one) or reads one
// point of the upscaled grid (kind 1, out_x / out_y). Every input beat gives
// exactly one output beat (out_valid / out_ready) with value and status.
// Configuration channel (cfg_valid / cfg_ready, always ready): index 0 sets
// grid_width, index 1 sets grid_height; write it only while the block is idle.
// A frame end that commits copies each cell of the frame (grid_width *
// grid_height) from the shadow memory to the active memory. A good read makes
// four neighbor reads through the one read port of the active memory and three
// passes through the five-stage interpolation unit. One item is in work at a
// time; in_ready is high only between items.
// After reset all MAX_WIDTH * MAX_HEIGHT entries of the active memory are cleared
// to zero, one entry per cycle, while in_ready stays low.
// A finished result sits in the output register until taken; the next input
// beat is accepted meanwhile, and its own result waits until the register
// frees up.
module thermal_grid_bilinear_upscale #(
  parameter int MAX_WIDTH       = 32,
  parameter int MAX_HEIGHT      = 32,
  parameter int INSERTED_POINTS = 3
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               kind,
  input  wire tgbu_pkg::sample_t                  sample,
  input  wire logic                               frame_end,
  input  wire logic [tgbu_pkg::COORD_W-1:0]       out_x,
  input  wire logic [tgbu_pkg::COORD_W-1:0]       out_y,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output tgbu_pkg::sample_t                       value,
  output logic [tgbu_pkg::STATUS_W-1:0]           status,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [tgbu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tgbu_pkg::CFG_W-1:0]         cfg_data
);

  import tgbu_pkg::*;

  localparam int STEPS      = INSERTED_POINTS + 1;
  localparam int TW         = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int GRID_CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = $clog2(GRID_CELLS);
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int DIV_SH     = 16;
  localparam int RX         = ((2 ** DIV_SH) + STEPS - 1) / STEPS;
  localparam int PROD_W     = COORD_W + DIV_SH + 1;

  localparam logic [DIV_SH:0] RX_C = (DIV_SH + 1)'(RX);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RDIV,
    S_RMOD,
    S_FETCH,
    S_FWAIT,
    S_COL,
    S_COL2,
    S_CWAIT,
    S_ROW,
    S_RWAIT,
    S_COMMIT,
    S_CEND,
    S_OUT
  } state_t;

  state_t state;

  logic [CFG_W-1:0] grid_width, grid_height;
  logic [COUNT_W-1:0] load_count;

  // Sweep and commit bookkeeping.
  logic [ADDR_W-1:0] sweep_addr, row_base, dst_q;
  logic [XW-1:0] cx;
  logic [YW-1:0] cy;
  logic rd_pend;

  // Read bookkeeping.
  logic [COORD_W-1:0] ox_q, oy_q, gx, gy;
  logic [TW-1:0] tx, ty;
  logic oor;
  logic [ADDR_W-1:0] base_addr;
  logic [1:0] fi, cap_idx;
  logic cap_pend;
  sample_t nb [4];
  sample_t left, right;
  logic col_got;

  sample_t res_value;
  status_t res_status;

  // Memory ports.
  logic              sh_we;
  logic [ADDR_W-1:0] sh_waddr;
  logic [DATA_W-1:0] sh_rdata;
  logic              act_we;
  logic [ADDR_W-1:0] act_waddr, act_raddr;
  logic [DATA_W-1:0] act_wdata, act_rdata;

  // Interpolation unit ports.
  logic    lp_in_valid, lp_out_valid;
  sample_t lp_a, lp_b, lp_result;
  logic [TW-1:0] lp_t;

  logic dims_ok, accept;
  logic [CELLS_W-1:0] cells, up_w, up_h;
  logic [COUNT_W-1:0] count_inc;
  logic [PROD_W-1:0] prod_x, prod_y;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;

  // Frame geometry from the current register values.
  always_comb begin
    dims_ok = (grid_width >= 6'd1) && (int'(grid_width) <= MAX_WIDTH) &&
              (grid_height >= 6'd1) && (int'(grid_height) <= MAX_HEIGHT);
    cells = CELLS_W'(grid_width) * CELLS_W'(grid_height);
    up_w  = CELLS_W'((CELLS_W'(grid_width) - CELLS_W'(1)) * CELLS_W'(STEPS)) + CELLS_W'(1);
    up_h  = CELLS_W'((CELLS_W'(grid_height) - CELLS_W'(1)) * CELLS_W'(STEPS)) + CELLS_W'(1);
    count_inc = (load_count < COUNT_MAX) ? (load_count + COUNT_W'(1)) : load_count;
  end

  // Upscaled coordinate split into grid index and step by a reciprocal.
  always_comb begin
    prod_x = PROD_W'(ox_q) * PROD_W'(RX_C);
    prod_y = PROD_W'(oy_q) * PROD_W'(RX_C);
  end

  // Shadow store is written on the load beat itself.
  always_comb begin
    sh_we    = accept && (kind == KIND_LOAD) && dims_ok &&
               (CELLS_W'(load_count) < cells);
    sh_waddr = ADDR_W'(load_count);
  end

  // Active store: clearing sweep, or the commit copy written in the cycle after its read.
  always_comb begin
    act_we    = (state == S_CLEAR) || rd_pend;
    act_waddr = (state == S_CLEAR) ? sweep_addr : dst_q;
    act_wdata = (state == S_CLEAR) ? '0 : sh_rdata;
    case (fi)
      2'd0:    act_raddr = base_addr;
      2'd1:    act_raddr = base_addr + ADDR_W'(MAX_WIDTH);
      2'd2:    act_raddr = base_addr + ADDR_W'(1);
      2'd3:    act_raddr = base_addr + ADDR_W'(MAX_WIDTH + 1);
      default: act_raddr = base_addr;
    endcase
  end

  // Operand selection for the interpolation unit.
  always_comb begin
    lp_in_valid = 1'b0;
    lp_a        = nb[0];
    lp_b        = nb[1];
    lp_t        = ty;
    case (state)
      S_COL: begin
        lp_in_valid = 1'b1;
      end
      S_COL2: begin
        lp_in_valid = 1'b1;
        lp_a        = nb[2];
        lp_b        = nb[3];
      end
      S_ROW: begin
        lp_in_valid = 1'b1;
        lp_a        = left;
        lp_b        = right;
        lp_t        = tx;
      end
      default: begin
        lp_in_valid = 1'b0;
      end
    endcase
  end

  tgbu_ram #(.WIDTH(DATA_W), .DEPTH(GRID_CELLS)) u_shadow (
    .clk   (clk),
    .we    (sh_we),
    .waddr (sh_waddr),
    .wdata (sample),
    .raddr (sweep_addr),
    .rdata (sh_rdata)
  );

  tgbu_ram #(.WIDTH(DATA_W), .DEPTH(GRID_CELLS)) u_active (
    .clk   (clk),
    .we    (act_we),
    .waddr (act_waddr),
    .wdata (act_wdata),
    .raddr (act_raddr),
    .rdata (act_rdata)
  );

  tgbu_lerp #(.STEPS(STEPS)) u_lerp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (lp_in_valid),
    .a         (lp_a),
    .b         (lp_b),
    .t         (lp_t),
    .out_valid (lp_out_valid),
    .result    (lp_result)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= RESET_DIM;
      grid_height <= RESET_DIM;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Neighbor capture, in the cycle after each read is issued.
  always_ff @(posedge clk) begin
    if (cap_pend) begin
      nb[cap_idx] <= sample_t'(act_rdata);
    end
  end

  // Main sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      sweep_addr <= '0;
      load_count <= '0;
      rd_pend    <= 1'b0;
      cap_pend   <= 1'b0;
      col_got    <= 1'b0;
      fi         <= '0;
      out_valid  <= 1'b0;
    end else begin
      rd_pend  <= (state == S_COMMIT);
      cap_pend <= (state == S_FETCH);
      cap_idx  <= fi;

      // The output register empties here unless a new result refills it.
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          sweep_addr <= sweep_addr + ADDR_W'(1);
          if (sweep_addr == ADDR_W'(GRID_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (accept) begin
            res_value <= '0;
            if (kind == KIND_LOAD) begin
              if (frame_end) begin
                load_count <= '0;
                if (dims_ok && (CELLS_W'(count_inc) == cells)) begin
                  sweep_addr <= '0;
                  row_base   <= '0;
                  cx         <= '0;
                  cy         <= '0;
                  state      <= S_COMMIT;
                end else begin
                  res_status <= ST_REJECTED;
                  state      <= S_OUT;
                end
              end else begin
                load_count <= count_inc;
                res_status <= ST_ACCEPTED;
                state      <= S_OUT;
              end
            end else begin
              ox_q  <= out_x;
              oy_q  <= out_y;
              state <= S_RDIV;
            end
          end
        end

        S_RDIV: begin
          gx    <= prod_x[DIV_SH +: COORD_W];
          gy    <= prod_y[DIV_SH +: COORD_W];
          oor   <= !dims_ok || (CELLS_W'(ox_q) >= up_w) || (CELLS_W'(oy_q) >= up_h);
          state <= S_RMOD;
        end

        S_RMOD: begin
          tx        <= TW'(ox_q - COORD_W'(32'(gx) * STEPS));
          ty        <= TW'(oy_q - COORD_W'(32'(gy) * STEPS));
          base_addr <= ADDR_W'(32'(gy) * MAX_WIDTH + 32'(gx));
          fi        <= '0;
          if (oor) begin
            res_value  <= '0;
            res_status <= ST_READ_OOR;
            state      <= S_OUT;
          end else begin
            state <= S_FETCH;
          end
        end

        S_FETCH: begin
          fi <= fi + 2'd1;
          if (fi == 2'd3) begin
            state <= S_FWAIT;
          end
        end

        S_FWAIT: begin
          state <= S_COL;
        end

        S_COL: begin
          col_got <= 1'b0;
          state   <= S_COL2;
        end

        S_COL2: begin
          state <= S_CWAIT;
        end

        // Left column comes back first, then the right one.
        S_CWAIT: begin
          if (lp_out_valid) begin
            if (!col_got) begin
              left    <= lp_result;
              col_got <= 1'b1;
            end else begin
              right <= lp_result;
              state <= S_ROW;
            end
          end
        end

        S_ROW: begin
          state <= S_RWAIT;
        end

        S_RWAIT: begin
          if (lp_out_valid) begin
            res_value  <= lp_result;
            res_status <= ST_READ_OK;
            state      <= S_OUT;
          end
        end

        // Shadow row-major cells go to the active store at a fixed row pitch.
        S_COMMIT: begin
          dst_q      <= row_base + ADDR_W'(cx);
          sweep_addr <= sweep_addr + ADDR_W'(1);
          if (cx == XW'(grid_width - 6'd1)) begin
            cx       <= '0;
            cy       <= cy + YW'(1);
            row_base <= row_base + ADDR_W'(MAX_WIDTH);
            if (cy == YW'(grid_height - 6'd1)) begin
              state <= S_CEND;
            end
          end else begin
            cx <= cx + XW'(1);
          end
        end

        S_CEND: begin
          res_value  <= '0;
          res_status <= ST_COMMITTED;
          state      <= S_OUT;
        end

        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            value     <= res_value;
            status    <= res_status;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Only a good read carries a nonzero value.
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_READ_OK)) |-> (value == '0))
    else $error("nonzero value on a result that is not a good read");

  // Every frame-end beat starts the next frame from an empty count.
  a_count_cleared: assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == KIND_LOAD) && frame_end) |=> (load_count == '0))
    else $error("load count not cleared after a frame end");

  // Interpolation results only arrive while the sequencer waits for them.
  a_lerp_sequencing: assert property (@(posedge clk) disable iff (rst)
    lp_out_valid |-> ((state == S_CWAIT) || (state == S_RWAIT)))
    else $error("interpolation result arrived outside a wait state");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import tgbu_pkg::*;

  localparam int MAX_W        = 32;
  localparam int MAX_H        = 32;
  localparam int INSERTED     = 3;
  localparam int STEPS        = INSERTED + 1;
  localparam int GRID_CELLS   = MAX_W * MAX_H;
  localparam int IDLE_LIMIT   = 20000;
  localparam int TAIL_CYCLES  = 40;
  localparam int REPORT_CAP   = 60;
  localparam int RANDOM_ITEMS = 200;

  // Register indexes that the block does not implement.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    sample_t value;
    status_t status;
  } pixel_result_t;

  // Tracks the loaded and committed frames and predicts one result per input beat.
  class upscale_tracker;
    sample_t pending_frame[GRID_CELLS];
    sample_t shown_frame[GRID_CELLS];
    logic [COUNT_W-1:0] samples_in;
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] rows;
    pixel_result_t awaited[$];
    int errors, reports, checked;
    int loads, commits, rejects, reads_ok, reads_oor, writes;

    function new();
      foreach (pending_frame[i]) pending_frame[i] = '0;
      foreach (shown_frame[i]) shown_frame[i] = '0;
      samples_in = '0;
      cols = RESET_DIM;
      rows = RESET_DIM;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      writes++;
      if (idx == CFG_GRID_WIDTH) cols = data;
      else if (idx == CFG_GRID_HEIGHT) rows = data;
    endfunction

    function bit dims_valid();
      return cols >= 1 && int'(cols) <= MAX_W && rows >= 1 && int'(rows) <= MAX_H;
    endfunction

    function int cell_count();
      return int'(cols) * int'(rows);
    endfunction

    function int upscaled_size(logic [CFG_W-1:0] n);
      return (int'(n) - 1) * STEPS + 1;
    endfunction

    // Moves t steps out of STEPS from a toward b, rounding toward minus infinity.
    function int blend(int a, int b, int t);
      int num;
      int q;
      num = t * (b - a);
      q = num / STEPS;
      if (num < 0 && q * STEPS != num) q = q - 1;
      return a + q;
    endfunction

    function int grid_at(int x, int y);
      return int'(shown_frame[(y * MAX_W + x) % GRID_CELLS]);
    endfunction

    // Value of grid column x at the row given by grid row gy and step ty.
    function int column_point(int x, int gy, int ty);
      int top;
      top = grid_at(x, gy);
      if (ty == 0) return top;
      return blend(top, grid_at(x, gy + 1), ty);
    endfunction

    function void note_item(logic k, sample_t s, logic fend,
                            logic [COORD_W-1:0] ox, logic [COORD_W-1:0] oy);
      pixel_result_t r;
      int cells, px, py, gx, gy, tx, ty, left, v;
      r.value = '0;
      cells = cell_count();
      if (k == KIND_LOAD) begin
        loads++;
        if (dims_valid() && int'(samples_in) < cells) pending_frame[int'(samples_in)] = s;
        if (samples_in != COUNT_MAX) samples_in = samples_in + 1'b1;
        r.status = ST_ACCEPTED;
        // A frame end commits only a frame of exactly the configured size.
        if (fend) begin
          if (dims_valid() && int'(samples_in) == cells) begin
            for (int y = 0; y < int'(rows); y++)
              for (int x = 0; x < int'(cols); x++)
                shown_frame[y * MAX_W + x] = pending_frame[y * int'(cols) + x];
            r.status = ST_COMMITTED;
            commits++;
          end else begin
            r.status = ST_REJECTED;
            rejects++;
          end
          samples_in = '0;
        end
      end else begin
        px = int'(ox);
        py = int'(oy);
        if (!dims_valid() || px >= upscaled_size(cols) || py >= upscaled_size(rows)) begin
          r.status = ST_READ_OOR;
          reads_oor++;
        end else begin
          gx = px / STEPS;
          tx = px % STEPS;
          gy = py / STEPS;
          ty = py % STEPS;
          left = column_point(gx, gy, ty);
          if (tx == 0) v = left;
          else v = blend(left, column_point(gx + 1, gy, ty), tx);
          r.value = 16'(v);
          r.status = ST_READ_OK;
          reads_ok++;
        end
      end
      awaited.push_back(r);
    endfunction

    function void flag(string field, int want_v, int got_v);
      errors++;
      if (reports < REPORT_CAP)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      reports++;
    endfunction

    function void check_result(sample_t v, logic [STATUS_W-1:0] st);
      pixel_result_t want;
      checked++;
      if (awaited.size() == 0) begin
        errors++;
        if (reports < REPORT_CAP)
          $display("%0t: result beat with nothing outstanding, expected none, actual %0d / %0d",
                   $time, v, st);
        reports++;
      end else begin
        want = awaited.pop_front();
        if (st !== want.status) flag("status", int'(want.status), int'(st));
        if (v !== want.value) flag("value", int'(want.value), int'(v));
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready;
  logic kind, frame_end;
  sample_t sample;
  logic [COORD_W-1:0] out_x, out_y;
  logic out_valid, out_ready;
  sample_t value;
  logic [STATUS_W-1:0] status;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  upscale_tracker sb;
  bit calm = 1'b0;
  int items_sent = 0;
  int idle_cycles = 0;

  thermal_grid_bilinear_upscale #(
    .MAX_WIDTH(MAX_W),
    .MAX_HEIGHT(MAX_H),
    .INSERTED_POINTS(INSERTED)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .sample(sample),
    .frame_end(frame_end),
    .out_x(out_x),
    .out_y(out_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .value(value),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Every output beat is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(value, status);
  end

  // The run ends when no beat of any channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output stalls: mostly short, a few long, none while the run is calm.
  initial begin
    int r;
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_ready = 1'b1;
          n = $urandom_range(1, 8);
        end else if (r < 92) begin
          out_ready = 1'b0;
          n = $urandom_range(1, 3);
        end else begin
          out_ready = 1'b0;
          n = $urandom_range(10, 60);
        end
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  function automatic int sender_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'sh7FFF;
    if (r == 1) return 16'sh8000;
    if (r == 2) return 16'($urandom_range(0, 511) - 256);
    return 16'($urandom);
  endfunction

  // Presents one input beat and holds it until the block takes it.
  task automatic send_item(input logic k, input sample_t s, input logic fe,
                           input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    sample = s;
    frame_end = fe;
    out_x = x;
    out_y = y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(k, s, fe, x, y);
    items_sent++;
  endtask

  // Stops sending and waits until every predicted result has come back.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
    @(negedge clk);
    in_valid = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // A run of load beats, optionally closed by a frame end on the last one.
  task automatic load_run(input int len, input bit closes);
    for (int i = 0; i < len; i++)
      send_item(KIND_LOAD, rand_sample(), closes && i == len - 1,
                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
  endtask

  // Reads mostly inside the upscaled grid, some on its edge, some anywhere.
  task automatic read_burst(input int n);
    int r, uw, uh;
    logic [COORD_W-1:0] x, y;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      uw = sb.upscaled_size(sb.cols);
      uh = sb.upscaled_size(sb.rows);
      if (sb.dims_valid() && r < 70) begin
        x = 7'($urandom_range(0, uw - 1));
        y = 7'($urandom_range(0, uh - 1));
      end else if (sb.dims_valid() && r < 85) begin
        x = 7'(uw - 1 + $urandom_range(0, 1));
        y = 7'($urandom_range(0, uh));
      end else begin
        x = 7'($urandom_range(0, 127));
        y = 7'($urandom_range(0, 127));
      end
      send_item(KIND_READ, rand_sample(), 1'($urandom_range(0, 1)), x, y);
    end
  endtask

  // One stretch of traffic; the lead stretch of a phase loads a whole frame when the grid is valid and fits frame_cap.
  task automatic episode(input bit lead, input int frame_cap);
    int cells, r, len;
    cells = sb.cell_count();
    r = lead ? 0 : $urandom_range(0, 99);
    if (r < 45 && sb.dims_valid() && cells <= frame_cap) begin
      load_run(cells, 1'b1);
    end else if (r < 75) begin
      read_burst($urandom_range(1, 12));
    end else if (r < 90) begin
      // Frames mostly of the wrong length.
      if (!sb.dims_valid() || cells > frame_cap) len = $urandom_range(1, 8);
      else begin
        case ($urandom_range(0, 2))
          0: len = (cells > 1) ? cells - 1 : cells + 1;
          1: len = cells + $urandom_range(1, 3);
          default: len = $urandom_range(1, cells + 3);
        endcase
      end
      load_run(len, 1'b1);
    end else begin
      load_run($urandom_range(1, 4), 1'b0);
    end
  endtask

  // Reconfigures the idle block, then runs a number of beats.
  task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input bit set_w, input bit set_h, input bit stray,
                           input int n_items, input int frame_cap, input bit quiet);
    int start;
    bit lead;
    settle();
    if (set_w) write_reg(CFG_GRID_WIDTH, w);
    if (set_h) write_reg(CFG_GRID_HEIGHT, h);
    if (stray) write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, 6'($urandom));
    calm = quiet;
    start = items_sent;
    lead = 1'b1;
    while (items_sent - start < n_items) begin
      episode(lead, frame_cap);
      lead = 1'b0;
    end
  endtask

  initial begin
    int r, random_goal;
    logic [CFG_W-1:0] w, h;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_LOAD;
    sample = '0;
    frame_end = 1'b0;
    out_x = '0;
    out_y = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GRID_WIDTH;
    cfg_data = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reads at the edges of the reset-size grid, before anything is committed.
    send_item(KIND_READ, 16'sh0000, 1'b0, 7'd0, 7'd0);
    send_item(KIND_READ, 16'sh0000, 1'b0, 7'd28, 7'd28);
    send_item(KIND_READ, 16'sh0000, 1'b0, 7'd29, 7'd28);
    send_item(KIND_READ, 16'sh0000, 1'b0, 7'd28, 7'd29);
    send_item(KIND_READ, 16'shFFFF, 1'b1, 7'd127, 7'd127);

    // A 2 by 2 frame: a lone frame end, a good frame of extremes, then reads.
    settle();
    write_reg(CFG_GRID_WIDTH, 6'd2);
    write_reg(CFG_GRID_HEIGHT, 6'd2);
    send_item(KIND_LOAD, 16'sh1234, 1'b1, 7'd0, 7'd0);
    send_item(KIND_LOAD, 16'sh7FFF, 1'b0, 7'd127, 7'd127);
    send_item(KIND_LOAD, 16'sh8000, 1'b0, 7'd127, 7'd0);
    send_item(KIND_LOAD, 16'sh8000, 1'b0, 7'd0, 7'd127);
    send_item(KIND_LOAD, 16'sh7FFF, 1'b1, 7'd85, 7'd42);
    send_item(KIND_READ, 16'sh0000, 1'b0, 7'd0, 7'd0);
    send_item(KIND_READ, 16'sh0000, 1'b0, 7'd4, 7'd4);
    send_item(KIND_READ, 16'sh0000, 1'b0, 7'd1, 7'd0);
    send_item(KIND_READ, 16'sh0000, 1'b0, 7'd2, 7'd3);
    send_item(KIND_READ, 16'sh7FFF, 1'b1, 7'd3, 7'd1);
    send_item(KIND_READ, 16'sh0000, 1'b0, 7'd4, 7'd0);
    send_item(KIND_READ, 16'sh0000, 1'b0, 7'd5, 7'd0);
    send_item(KIND_READ, 16'sh0000, 1'b0, 7'd0, 7'd5);
    // Too many samples for the frame.
    load_run(5, 1'b1);

    // One frame that runs well past its size, then a good one.
    run_phase(6'd2, 6'd1, 1'b1, 1'b1, 1'b0, 0, 0, 1'b1);
    load_run(12, 1'b1);
    load_run(2, 1'b1);
    read_burst(6);

    // The widest, tallest and largest grids, bad sizes and the smallest grid.
    run_phase(6'd32, 6'd1, 1'b1, 1'b1, 1'b0, 60, 64, 1'b0);
    run_phase(6'd1, 6'd32, 1'b1, 1'b1, 1'b0, 60, 64, 1'b0);
    run_phase(6'd32, 6'd32, 1'b1, 1'b1, 1'b0, GRID_CELLS, GRID_CELLS, 1'b0);
    read_burst(40);
    run_phase(6'd0, 6'd32, 1'b1, 1'b0, 1'b0, 20, 64, 1'b0);
    run_phase(6'd63, 6'd33, 1'b1, 1'b1, 1'b1, 20, 64, 1'b1);
    run_phase(6'd33, 6'd5, 1'b1, 1'b1, 1'b0, 15, 64, 1'b0);
    run_phase(6'd5, 6'd0, 1'b1, 1'b1, 1'b1, 15, 64, 1'b0);
    run_phase(6'd1, 6'd1, 1'b1, 1'b1, 1'b0, 30, 64, 1'b0);

    // Random phases, mostly small grids with whole frames of random content.
    random_goal = items_sent + RANDOM_ITEMS;
    while (items_sent < random_goal) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        w = 6'($urandom_range(1, 6));
        h = 6'($urandom_range(1, 6));
      end else if (r < 80) begin
        w = 6'($urandom_range(1, 32));
        h = 6'($urandom_range(1, 3));
      end else if (r < 88) begin
        w = 6'($urandom_range(1, 3));
        h = 6'($urandom_range(1, 32));
      end else begin
        w = (r < 94) ? 6'd0 : 6'($urandom_range(33, 63));
        h = 6'($urandom_range(0, 63));
      end
      run_phase(w, h, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                $urandom_range(0, 7) == 0, $urandom_range(30, 80), 128,
                $urandom_range(0, 4) == 0);
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.awaited.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.awaited.size());
    end
    $display("Covered %0d load beats, %0d frames committed and %0d rejected, %0d register writes.",
             sb.loads, sb.commits, sb.rejects, sb.writes);
    $display("Covered %0d reads inside the upscaled grid and %0d outside; %0d results, %0d errors.",
             sb.reads_ok, sb.reads_oor, sb.checked, sb.errors);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
design/tgbu_pkg.sv
design/tgbu_ram.sv
design/tgbu_lerp.sv
design/thermal_grid_bilinear_upscale.sv
tb/tb_top.sv
